### rtl/clrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clrd_pkg
// Shared types and constants for the code-length run-length decoder.
// ----------------------------------------------------------------------------
package clrd_pkg;

  // Status codes reported on the result that ends the table
  typedef enum logic [2:0] {
    StOk             = 3'd0,
    StTruncRepeat    = 3'd1,
    StRepeatOverrun  = 3'd2,
    StTruncLiteral   = 3'd3,
    StLiteralOverrun = 3'd4,
    StUnfilled       = 3'd5
  } status_e;

  // Tag decoding
  localparam logic [7:0] RepeatOffset = 8'd3;

  // One classified stream byte, handed from the front part to the back part
  typedef struct packed {
    logic [7:0] data;       // stream byte
    logic       active;     // byte lies within the coded stream
    logic       last;       // last byte of the coded stream
    logic       lit_trunc;  // a literal tag here would run past the stream end
  } qitem_t;

endpackage

### rtl/clrd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clrd_front
// Holds the stream length, counts accepted bytes and classifies each byte
// by its place in the coded stream before it enters the queue.
// ----------------------------------------------------------------------------
module clrd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_data_i,
  input  logic            push_i,
  input  logic [7:0]      data_byte_i,
  output clrd_pkg::qitem_t item_o
);
  import clrd_pkg::*;

  logic [15:0] len_q, len_d;
  logic [15:0] seen_q, seen_d;
  logic [15:0] seen_inc;
  logic [15:0] remaining;
  logic        active;

  assign seen_inc  = seen_q + 16'd1;
  assign active    = seen_q < len_q;
  // bytes left after this one
  assign remaining = len_q - seen_inc;

  // Classification of the byte on the input
  always_comb begin
    item_o.data      = data_byte_i;
    item_o.active    = active;
    item_o.last      = active && (seen_inc == len_q);
    // tag + 1 > remaining  <=>  tag >= remaining
    item_o.lit_trunc = {8'd0, data_byte_i} >= remaining;
  end

  // Length register and byte counter; a length write re-arms the count
  always_comb begin
    len_d  = len_q;
    seen_d = seen_q;
    if (cfg_we_i) begin
      len_d  = cfg_data_i;
      seen_d = '0;
    end else if (push_i && active) begin
      seen_d = seen_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      seen_q <= '0;
    end else begin
      len_q  <= len_d;
      seen_q <= seen_d;
    end
  end

endmodule

### rtl/clrd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clrd_queue
// Two-entry queue of classified bytes between the front and back parts.
// ----------------------------------------------------------------------------
module clrd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             push_i,
  input  clrd_pkg::qitem_t item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output clrd_pkg::qitem_t item_o
);
  import clrd_pkg::*;

  qitem_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign item_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else if (clear_i) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Checks
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i) else $error("queue overflow");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue underflow");
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");

endmodule

### rtl/clrd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clrd_back
// Runs the tag/payload sequence on queued bytes, tracks the fill position
// and first error, and holds each result in an output register.
// ----------------------------------------------------------------------------
module clrd_back #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             q_valid_i,
  input  clrd_pkg::qitem_t item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             write_valid_o,
  output logic [7:0]       write_index_o,
  output logic [7:0]       write_count_o,
  output logic [7:0]       write_value_o,
  output logic             done_res_o,
  output logic [2:0]       status_o
);
  import clrd_pkg::*;

  localparam int unsigned FillW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned IdxW  = (FillW > 8) ? FillW : 8;
  localparam logic [IdxW:0] TableEnd = (IdxW + 1)'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    PhTag     = 2'd0,
    PhRepeat  = 2'd1,
    PhLiteral = 2'd2,
    PhAbsorb  = 2'd3
  } phase_e;

  phase_e         phase_q, phase_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [7:0]     pend_q, pend_d;
  status_e        err_q, err_d;

  logic           out_valid_q;
  logic           wv_q, wv_d;
  logic [7:0]     wi_q, wi_d, wc_q, wc_d, wval_q, wval_d;
  logic           done_q, done_d;
  status_e        st_q, st_d;

  logic [IdxW-1:0] fill_ext;
  logic [7:0]     run;
  logic [IdxW:0]  run_end;

  assign pop_o    = q_valid_i && (!out_valid_q || out_ready_i);
  assign fill_ext = IdxW'(fill_q);

  // Run length of a tag and the entry just past it
  assign run     = item_i.data[7] ? ({1'b0, item_i.data[6:0]} + RepeatOffset)
                                  : (item_i.data + 8'd1);
  assign run_end = (IdxW + 1)'(fill_q) + (IdxW + 1)'(run);

  // Decode step for the byte at the head of the queue
  always_comb begin
    phase_d = phase_q;
    fill_d  = fill_q;
    pend_d  = pend_q;
    err_d   = err_q;
    wv_d    = 1'b0;
    wi_d    = '0;
    wc_d    = '0;
    wval_d  = '0;
    done_d  = 1'b0;
    st_d    = StOk;
    if (item_i.active) begin
      case (phase_q)
        PhTag: begin
          if (item_i.data[7]) begin
            if (item_i.last) begin
              err_d   = StTruncRepeat;
              phase_d = PhAbsorb;
            end else if (run_end > TableEnd) begin
              err_d   = StRepeatOverrun;
              phase_d = PhAbsorb;
            end else begin
              pend_d  = run;
              phase_d = PhRepeat;
            end
          end else begin
            if (item_i.lit_trunc) begin
              err_d   = StTruncLiteral;
              phase_d = PhAbsorb;
            end else if (run_end > TableEnd) begin
              err_d   = StLiteralOverrun;
              phase_d = PhAbsorb;
            end else begin
              pend_d  = run;
              phase_d = PhLiteral;
            end
          end
        end
        PhRepeat: begin
          wv_d    = 1'b1;
          wi_d    = fill_ext[7:0];
          wc_d    = pend_q;
          wval_d  = item_i.data;
          fill_d  = fill_q + FillW'(pend_q);
          pend_d  = '0;
          phase_d = PhTag;
        end
        PhLiteral: begin
          wv_d    = 1'b1;
          wi_d    = fill_ext[7:0];
          wc_d    = 8'd1;
          wval_d  = item_i.data;
          fill_d  = fill_q + FillW'(1);
          pend_d  = pend_q - 8'd1;
          if (pend_q == 8'd1) phase_d = PhTag;
        end
        default: ;
      endcase
      // End of the coded stream: report the first error or the fill result
      if (item_i.last) begin
        done_d = 1'b1;
        if (err_d != StOk) begin
          st_d = err_d;
        end else if ((IdxW + 1)'(fill_d) != TableEnd) begin
          st_d = StUnfilled;
        end
      end
    end
  end

  // Decoder state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhTag;
      fill_q      <= '0;
      pend_q      <= '0;
      err_q       <= StOk;
      out_valid_q <= 1'b0;
      wv_q        <= 1'b0;
      wi_q        <= '0;
      wc_q        <= '0;
      wval_q      <= '0;
      done_q      <= 1'b0;
      st_q        <= StOk;
    end else if (clear_i) begin
      phase_q     <= PhTag;
      fill_q      <= '0;
      pend_q      <= '0;
      err_q       <= StOk;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q     <= phase_d;
        fill_q      <= fill_d;
        pend_q      <= pend_d;
        err_q       <= err_d;
        out_valid_q <= 1'b1;
        wv_q        <= wv_d;
        wi_q        <= wi_d;
        wc_q        <= wc_d;
        wval_q      <= wval_d;
        done_q      <= done_d;
        st_q        <= st_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign write_valid_o = wv_q;
  assign write_index_o = wi_q;
  assign write_count_o = wc_q;
  assign write_value_o = wval_q;
  assign done_res_o    = done_q;
  assign status_o      = st_q;

  // Checks
  a_status_only_on_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !done_q |-> st_q == StOk) else $error("status without done");
  a_no_write_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !wv_q |-> (wc_q == 8'd0) && (wi_q == 8'd0) && (wval_q == 8'd0))
    else $error("write fields set without write");
  a_fill_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (IdxW + 1)'(fill_q) <= TableEnd) else $error("fill position past table end");
  a_error_absorbs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != StOk |-> phase_q == PhAbsorb) else $error("error held outside absorb");

endmodule

### rtl/code_length_rle_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// code_length_rle_decoder_unit
// Decodes a run-length coded code-length table into table write commands,
// one stream byte in and one result out per transfer.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  input    in_valid_i/in_ready_o  data_byte_i
//  output   out_valid_o/out_ready_i write_valid_o, write_index_o,
//                                  write_count_o, write_value_o,
//                                  done_res_o, status_o
//  config   cfg_we_i               cfg_data_i (encoded length)
//
// One byte per cycle sustained while out_ready_i stays high; a result reaches
// the output register through the queue write and then the decode register.
// The sequencer updates its fill position and phase together for each byte, which
// sets the rate. The two-entry queue lets input keep flowing for two bytes
// while the output is stalled. Reset, or a length write, re-arms the
// decoder. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module code_length_rle_decoder_unit #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        write_valid_o,
  output logic [7:0]  write_index_o,
  output logic [7:0]  write_count_o,
  output logic [7:0]  write_value_o,
  output logic        done_res_o,
  output logic [2:0]  status_o
);
  import clrd_pkg::*;

  qitem_t front_item, q_item;
  logic   q_full, q_valid, q_pop, push;

  assign in_ready_o = !q_full;
  assign push       = in_valid_i && !q_full;

  clrd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .data_byte_i (data_byte_i),
    .item_o      (front_item)
  );

  clrd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg_we_i),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  clrd_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (cfg_we_i),
    .q_valid_i     (q_valid),
    .item_i        (q_item),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .write_valid_o (write_valid_o),
    .write_index_o (write_index_o),
    .write_count_o (write_count_o),
    .write_value_o (write_value_o),
    .done_res_o    (done_res_o),
    .status_o      (status_o)
  );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the code-length run-length decoder. A directed
// table covers reset, the extremes of runs and each error ending; random
// phases then feed mostly well-formed tables with random content, mixed with
// cut-short, overlong, overrunning and noise streams. Every result transfer
// is compared with a typed row result or a bench-side behavioural decoder.
// ----------------------------------------------------------------------------
module tb_top;
  import clrd_pkg::*;

  localparam int unsigned TableEntries = 256;
  localparam int unsigned WatchLimit   = 1000;  // cycles without a transfer
  localparam int unsigned HoldCycles   = 150;   // long receiver hold-off
  localparam int unsigned DrainCycles  = 6;
  localparam int unsigned ItemTarget   = 450;

  // Decoder phase as tracked by the bench
  typedef enum logic [1:0] {
    PhTag     = 2'd0,
    PhRepeat  = 2'd1,
    PhLiteral = 2'd2,
    PhAbsorb  = 2'd3
  } dec_phase_e;

  // One result: a table write command plus end-of-table status
  typedef struct packed {
    logic       wr;
    logic [7:0] idx;
    logic [7:0] cnt;
    logic [7:0] val;
    logic       done;
    status_e    st;
  } table_write_t;

  // One row of the directed table: a length write or a stream byte
  typedef struct {
    bit           is_cfg;
    logic [15:0]  val;
    bit           typed;
    table_write_t res;
  } stim_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        write_valid_o;
  logic [7:0]  write_index_o;
  logic [7:0]  write_count_o;
  logic [7:0]  write_value_o;
  logic        done_res_o;
  logic [2:0]  status_o;

  // Typed expectation travelling with the byte on offer
  logic         typed_row = 1'b0;
  table_write_t typed_exp = '0;

  table_write_t writes_due[$];
  logic [7:0]   phase_bytes[$];
  stim_row_t    dir_tab[$];
  int unsigned  mismatch_cnt = 0;
  bit           calm    = 1'b0;
  bit           squeeze = 1'b0;

  // Bench copy of the decoder state
  int unsigned  stream_len = 0;
  int unsigned  seen_cnt   = 0;
  int unsigned  fill_pos   = 0;
  logic [7:0]   run_left   = '0;
  status_e      held_err   = StOk;
  dec_phase_e   dec_phase  = PhTag;

  code_length_rle_decoder_unit #(
    .TABLE_ENTRIES(TableEntries)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .write_valid_o(write_valid_o),
    .write_index_o(write_index_o),
    .write_count_o(write_count_o),
    .write_value_o(write_value_o),
    .done_res_o   (done_res_o),
    .status_o     (status_o)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Behavioural decoder
  // --------------------------------------------------------------------------
  function automatic void set_length(input logic [15:0] len);
    stream_len = {16'd0, len};
    seen_cnt   = 0;
    fill_pos   = 0;
    run_left   = '0;
    held_err   = StOk;
    dec_phase  = PhTag;
  endfunction

  function automatic void hold_error(input status_e code);
    held_err  = code;
    dec_phase = PhAbsorb;
  endfunction

  function automatic table_write_t decode_byte(input logic [7:0] b);
    table_write_t r;
    int unsigned  left;
    int unsigned  run;
    r = '0;
    if (seen_cnt < stream_len) begin
      left = stream_len - (seen_cnt + 1);
      case (dec_phase)
        PhTag: begin
          if (b[7]) begin
            run = {25'd0, b[6:0]} + 3;
            if (left == 0) hold_error(StTruncRepeat);
            else if (fill_pos + run > TableEntries) hold_error(StRepeatOverrun);
            else begin
              run_left  = 8'(run);
              dec_phase = PhRepeat;
            end
          end else begin
            run = {24'd0, b} + 1;
            // truncation is checked ahead of overrun
            if (run > left) hold_error(StTruncLiteral);
            else if (fill_pos + run > TableEntries) hold_error(StLiteralOverrun);
            else begin
              run_left  = 8'(run);
              dec_phase = PhLiteral;
            end
          end
        end
        PhRepeat: begin
          r.wr      = 1'b1;
          r.idx     = fill_pos[7:0];
          r.cnt     = run_left;
          r.val     = b;
          fill_pos  = fill_pos + {24'd0, run_left};
          run_left  = '0;
          dec_phase = PhTag;
        end
        PhLiteral: begin
          r.wr     = 1'b1;
          r.idx    = fill_pos[7:0];
          r.cnt    = 8'd1;
          r.val    = b;
          fill_pos = fill_pos + 1;
          run_left = run_left - 8'd1;
          if (run_left == 8'd0) dec_phase = PhTag;
        end
        default: ;
      endcase
      seen_cnt = seen_cnt + 1;
      if (seen_cnt == stream_len) begin
        r.done = 1'b1;
        if (held_err != StOk) r.st = held_err;
        else if (fill_pos != TableEntries) r.st = StUnfilled;
        else r.st = StOk;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want, got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Model update, expectation store and result compare, all at the edge
  always @(posedge clk_i) begin : monitor
    table_write_t want;
    if (rst_ni) begin
      if (cfg_we_i) set_length(cfg_data_i);
      if (out_valid_o && out_ready_i) begin
        if (writes_due.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual %0d/%0d/%0d",
                   $time, write_index_o, write_count_o, write_value_o);
          mismatch_cnt++;
        end else begin
          want = writes_due.pop_front();
          check_field("write_valid", 8'(want.wr), 8'(write_valid_o));
          check_field("write_index", want.idx, write_index_o);
          check_field("write_count", want.cnt, write_count_o);
          check_field("write_value", want.val, write_value_o);
          check_field("done_res", 8'(want.done), 8'(done_res_o));
          check_field("status", 8'(want.st), 8'(status_o));
        end
      end
      // pop before push: a result never belongs to the byte of the same edge
      if (in_valid_i && in_ready_o) begin
        want = decode_byte(data_byte_i);
        writes_due.insert(writes_due.size(), typed_row ? typed_exp : want);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles without any transfer
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WatchLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready bursts, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    @(posedge rst_ni);
    forever begin
      if (squeeze) begin
        squeeze = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input bit typed,
                           input table_write_t res);
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    typed_row   <= typed;
    typed_exp   <= res;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Wait for every expected result, then let the pipeline empty
  task automatic settle();
    do @(posedge clk_i); while (writes_due.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [15:0] len);
    in_valid_i <= 1'b0;
    settle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= len;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] len);
    write_length(len);
    foreach (phase_bytes[i]) begin
      send_byte(phase_bytes[i], 1'b0, '0);
      maybe_gap();
    end
  endtask

  function automatic table_write_t mk_res(input logic wr, input logic [7:0] idx,
                                          input logic [7:0] cnt, input logic [7:0] val,
                                          input logic done, input status_e st);
    table_write_t r;
    r.wr   = wr;
    r.idx  = idx;
    r.cnt  = cnt;
    r.val  = val;
    r.done = done;
    r.st   = st;
    return r;
  endfunction

  function automatic void add_cfg(input logic [15:0] len);
    stim_row_t r;
    r.is_cfg = 1'b1;
    r.val    = len;
    r.typed  = 1'b0;
    r.res    = '0;
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  function automatic void add_byte(input logic [7:0] b, input bit typed,
                                   input table_write_t res);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.val    = {8'h00, b};
    r.typed  = typed;
    r.res    = res;
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  // Random stream: mostly complete tables, some cut short, overlong,
  // overrunning or plain noise
  task automatic build_phase(output logic [15:0] len);
    int unsigned kind;
    int unsigned fill;
    int unsigned left;
    int unsigned run;
    int unsigned slack;
    int unsigned cap;
    int unsigned extra;
    logic [7:0]  v;
    phase_bytes.delete();
    kind  = $urandom_range(0, 9);
    slack = (kind == 9) ? $urandom_range(1, 24) : 0;
    if (kind == 8) begin
      len = 16'($urandom_range(1, 40));
      repeat (len) begin
        v = 8'($urandom_range(0, 255));
        phase_bytes.insert(phase_bytes.size(), v);
      end
    end else begin
      fill = 0;
      while (fill < TableEntries) begin
        left = TableEntries - fill;
        if (left + slack >= 3 && $urandom_range(0, 1) == 1) begin
          cap = (left + slack > 130) ? 130 : left + slack;
          run = $urandom_range(3, cap);
          v   = 8'(run - 3);
          phase_bytes.insert(phase_bytes.size(), 8'h80 | v);
          v   = 8'($urandom_range(0, 255));
          phase_bytes.insert(phase_bytes.size(), v);
        end else begin
          cap = ($urandom_range(0, 7) == 0) ? 128 : 6;
          if (cap > left + slack) cap = left + slack;
          run = $urandom_range(1, cap);
          v   = 8'(run - 1);
          phase_bytes.insert(phase_bytes.size(), v);
          repeat (run) begin
            v = 8'($urandom_range(0, 255));
            phase_bytes.insert(phase_bytes.size(), v);
          end
        end
        fill = fill + run;
      end
      len = 16'(phase_bytes.size());
      if (kind == 6) begin
        len = 16'($urandom_range(1, phase_bytes.size()));
      end else if (kind == 7) begin
        extra = $urandom_range(1, 8);
        len   = len + 16'(extra);
        repeat (extra) begin
          v = 8'($urandom_range(0, 255));
          phase_bytes.insert(phase_bytes.size(), v);
        end
      end
    end
    // now and then a few bytes past the end of the table
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        v = 8'($urandom_range(0, 255));
        phase_bytes.insert(phase_bytes.size(), v);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    table_write_t none;
    logic [15:0]  len;
    logic [7:0]   v;
    int unsigned  counted;
    int unsigned  plen;
    bit           first;
    none    = '0;
    counted = 0;
    first   = 1'b1;

    // zero length after reset: bytes absorbed
    add_byte(8'hFF, 1'b1, none);
    // short repeat, table left unfilled, then a byte past the end
    add_cfg(16'd2);
    add_byte(8'h80, 1'b1, none);
    add_byte(8'h0F, 1'b1, mk_res(1'b1, 8'd0, 8'd3, 8'h0F, 1'b1, StUnfilled));
    add_byte(8'hAA, 1'b1, none);
    // repeat tag as the last byte
    add_cfg(16'd1);
    add_byte(8'h85, 1'b1, mk_res(1'b0, 8'd0, 8'd0, 8'd0, 1'b1, StTruncRepeat));
    // literal run past the stream end, rest absorbed
    add_cfg(16'd3);
    add_byte(8'h02, 1'b1, none);
    add_byte(8'h11, 1'b1, none);
    add_byte(8'h22, 1'b1, mk_res(1'b0, 8'd0, 8'd0, 8'd0, 1'b1, StTruncLiteral));
    // two longest-ish repeats filling the table exactly
    add_cfg(16'd4);
    add_byte(8'hFF, 1'b1, none);
    add_byte(8'h00, 1'b1, mk_res(1'b1, 8'd0, 8'd130, 8'h00, 1'b0, StOk));
    add_byte(8'hFB, 1'b1, none);
    add_byte(8'hFF, 1'b1, mk_res(1'b1, 8'd130, 8'd126, 8'hFF, 1'b1, StOk));
    // repeat overrun
    add_cfg(16'd4);
    add_byte(8'hFF, 1'b0, none);
    add_byte(8'h01, 1'b0, none);
    add_byte(8'hFF, 1'b0, none);
    add_byte(8'h00, 1'b0, none);
    // literal overrun near the top of the table
    add_cfg(16'd8);
    add_byte(8'hFF, 1'b0, none);
    add_byte(8'h07, 1'b0, none);
    add_byte(8'hF9, 1'b0, none);
    add_byte(8'h08, 1'b0, none);
    add_byte(8'h02, 1'b0, none);
    add_byte(8'h7F, 1'b0, none);
    add_byte(8'h00, 1'b0, none);
    add_byte(8'h01, 1'b0, none);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        write_length(dir_tab[i].val);
      end else begin
        send_byte(dir_tab[i].val[7:0], dir_tab[i].typed, dir_tab[i].res);
        maybe_gap();
      end
    end

    // register extremes: explicit zero and the longest stream
    phase_bytes.delete();
    repeat (3) begin
      v = 8'($urandom_range(0, 255));
      phase_bytes.insert(phase_bytes.size(), v);
    end
    run_phase(16'd0);
    phase_bytes.delete();
    repeat (6) begin
      v = 8'($urandom_range(0, 255));
      phase_bytes.insert(phase_bytes.size(), v);
    end
    run_phase(16'hFFFF);

    // random phases; the first one runs against a long receiver hold-off
    while (counted < ItemTarget) begin
      build_phase(len);
      if (counted >= ItemTarget - 70) calm = 1'b1;
      if (first) squeeze = 1'b1;
      first = 1'b0;
      run_phase(len);
      plen    = phase_bytes.size();
      counted = counted + ((plen < {16'd0, len}) ? plen : {16'd0, len});
    end

    in_valid_i <= 1'b0;
    settle();
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
